>>> sv/rtdt_pkg.sv
// shared types and constants for the rtd code to temperature pipeline
package rtdt_pkg;

  // field and register widths
  localparam int RAW_W     = 16;
  localparam int CODE_BITS = 15;
  localparam int FRAC_BITS = 8;
  localparam int NOM_W     = 10;
  localparam int REF_W     = 14;
  localparam int TEMP_W    = 19;
  localparam int N_W       = CODE_BITS + REF_W;

  // ratio divider: dividend is (n - m) << 17 or 100 * n, divisor is nominal
  localparam int RATIO_SHIFT = 32 - CODE_BITS;
  localparam int DIVD_W      = 46;

  // quadratic branch widths
  localparam int Y_W    = 36;
  localparam int YH_W   = Y_W / 2;
  localparam int K_W    = 28;
  localparam int PP_W   = K_W + YH_W;
  localparam int RAD_W  = 64;
  localparam int ROOT_W = RAD_W / 2;
  localparam int DEN_W  = 33;
  localparam int NUM_W  = 52;
  localparam int QT_W   = 21;
  localparam int SQ_KEEP_W = Y_W + TEMP_W;

  // polynomial branch widths
  localparam int U_W     = 22;
  localparam int ACC_W   = 48;
  localparam int STEPS   = 5;
  localparam int POLY_SH = 32 - FRAC_BITS;

  // configuration register indexes
  localparam logic REG_NOMINAL   = 1'b0;
  localparam logic REG_REFERENCE = 1'b1;

  localparam logic [NOM_W-1:0] NOMINAL_RST   = NOM_W'(100);
  localparam logic [REF_W-1:0] REFERENCE_RST = REF_W'(430);

  // output range
  localparam logic signed [TEMP_W-1:0] TEMP_MAX = 19'sd262143;
  localparam logic signed [TEMP_W-1:0] TEMP_MIN = -19'sd65536;

  // inverse quadratic constants: A in Q39, 4|B| in Q46
  localparam logic [31:0]    CVD_A_Q39  = 32'd2148610647;
  localparam logic [K_W-1:0] CVD_4B_Q46 = 28'd162551799;
  localparam logic [63:0]    CVD_A_SQ   = 64'(CVD_A_Q39) * 64'(CVD_A_Q39);

  // polynomial coefficients scaled by 128^k, Q32
  localparam logic signed [ACC_W-1:0] POLY_Q32 [6] = '{
    -48'sd1039467984978, 48'sd1221997223110, 48'sd181966535569,
    -48'sd43468743605, -48'sd32492786764, 48'sd22494697593
  };

  // control flags that ride with every item
  typedef struct packed {
    logic valid;
    logic fault;
    logic poly;
    logic sat;
  } tag_t;

endpackage

>>> sv/rtd_code_to_temperature.sv
// top level: platinum rtd converter word to temperature in 1/256 degree C
//
// Converts the raw 16-bit rtd register word into a saturated signed temperature.
// Bit 0 is passed out as fault_seen; bits 15..1 are the ratio code. At or above
// 0 C the inverse Callendar-Van Dusen quadratic is used (square root and divide),
// below 0 C a fifth order polynomial, flagged by used_polynomial, which is also
// set when the ratio lies beyond the quadratic and the output saturates high.
// The pipeline takes one transaction per clock while no result is held at the
// output; most of its depth lies in the bit-per-stage ratio divider (46
// stages), square root (32 stages) and final divider (21 stages). When the
// output is held by out_ready low the whole pipeline stalls in place.
// nominal_ohms (index 0, reset 100) and reference_ohms (index 1, reset 430) may
// be written only while no transaction is in flight; cfg_ready is always high.
module rtd_code_to_temperature import rtdt_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic                     cfg_index,
  input  logic [REF_W-1:0]         cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [RAW_W-1:0]         raw_word,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [TEMP_W-1:0] temperature,
  output logic                     fault_seen,
  output logic                     used_polynomial
);

  logic [NOM_W-1:0] nominal_ohms;
  logic [REF_W-1:0] reference_ohms;
  logic [NOM_W-1:0] nom_eff;
  logic             en;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      nominal_ohms   <= NOMINAL_RST;
      reference_ohms <= REFERENCE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_NOMINAL:   nominal_ohms   <= cfg_data[NOM_W-1:0];
        REG_REFERENCE: reference_ohms <= cfg_data;
      endcase
    end
  end

  // a zero nominal acts as one
  assign nom_eff = (nominal_ohms == '0) ? NOM_W'(1) : nominal_ohms;

  // global advance: the pipeline moves unless a result is held at the output
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // stage 0: ratio product
  tag_t           s0_tag;
  logic [N_W-1:0] s0_n;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_tag <= '0;
    end else if (en) begin
      s0_tag <= '{valid: in_valid, fault: raw_word[0], poly: 1'b0, sat: 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_n <= raw_word[RAW_W-1:1] * reference_ohms;
    end
  end

  // stage 1: branch choice and divider operand
  logic [N_W-1:0]    s0_m;
  logic              s0_quad;
  tag_t              s1_tag;
  logic [DIVD_W-1:0] s1_dividend;

  assign s0_m    = N_W'({nom_eff, {CODE_BITS{1'b0}}});
  assign s0_quad = s0_n >= s0_m;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_tag <= '0;
    end else if (en) begin
      s1_tag <= '{valid: s0_tag.valid, fault: s0_tag.fault, poly: !s0_quad,
                  sat: s0_tag.sat};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (s0_quad) begin
        s1_dividend <= DIVD_W'(s0_n - s0_m) << RATIO_SHIFT;
      end else begin
        s1_dividend <= DIVD_W'(s0_n) * DIVD_W'(100);
      end
    end
  end

  // ratio divide: y in Q32 or u in Q22
  tag_t              dv_tag;
  logic [DIVD_W-1:0] dv_q;

  rtdt_ratio_div u_ratio_div (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .divisor      (nom_eff),
    .in_tag       (s1_tag),
    .in_dividend  (s1_dividend),
    .out_tag      (dv_tag),
    .out_quotient (dv_q)
  );

  // stage p: out of range check, split into branch operands
  logic           dv_over;
  tag_t           sp_tag;
  logic [Y_W-1:0] sp_y;
  logic [U_W-1:0] sp_u;

  assign dv_over = (|dv_q[DIVD_W-1:Y_W]) || (dv_q[Y_W-1] && (|dv_q[Y_W-2:0]));

  always_ff @(posedge clk) begin
    if (rst) begin
      sp_tag <= '0;
    end else if (en) begin
      sp_tag <= '{valid: dv_tag.valid, fault: dv_tag.fault, poly: dv_tag.poly,
                  sat: !dv_tag.poly && dv_over};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sp_y <= dv_q[Y_W-1:0];
      sp_u <= dv_q[U_W-1:0];
    end
  end

  // polynomial branch
  tag_t                    hn_tag;
  logic signed [ACC_W-1:0] hn_acc;
  logic [Y_W-1:0]          hn_y;

  rtdt_horner u_horner (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_tag   (sp_tag),
    .in_u     (sp_u),
    .in_keep  (sp_y),
    .out_tag  (hn_tag),
    .out_acc  (hn_acc),
    .out_keep (hn_y)
  );

  // stage r: polynomial rounding and quadratic partial products
  logic [ACC_W-1:0]          hn_abs;
  logic [ACC_W-1:0]          hn_mag;
  logic signed [TEMP_W-1:0]  hn_temp;
  tag_t                      sr_tag;
  logic [Y_W-1:0]            sr_y;
  logic signed [TEMP_W-1:0]  sr_temp;
  logic [PP_W-1:0]           sr_plo;
  logic [PP_W-1:0]           sr_phi;

  assign hn_abs = hn_acc[ACC_W-1] ? ACC_W'(-hn_acc) : hn_acc;
  assign hn_mag = (hn_abs + (ACC_W'(1) << (POLY_SH - 1))) >> POLY_SH;

  // round half away from zero, then clamp
  always_comb begin
    if (hn_acc[ACC_W-1]) begin
      if (hn_mag > ACC_W'(65536)) begin
        hn_temp = TEMP_MIN;
      end else begin
        hn_temp = TEMP_W'(-hn_mag);
      end
    end else begin
      if (hn_mag > ACC_W'(TEMP_MAX)) begin
        hn_temp = TEMP_MAX;
      end else begin
        hn_temp = hn_mag[TEMP_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sr_tag <= '0;
    end else if (en) begin
      sr_tag <= hn_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sr_y    <= hn_y;
      sr_temp <= hn_temp;
      sr_plo  <= CVD_4B_Q46 * hn_y[YH_W-1:0];
      sr_phi  <= CVD_4B_Q46 * hn_y[Y_W-1:YH_W];
    end
  end

  // stage d: discriminant A^2 - 4|B| y
  logic [63:0]              sr_kd;
  logic [64:0]              sr_diff;
  tag_t                     sd_tag;
  logic [RAD_W-1:0]         sd_rad;
  logic [Y_W-1:0]           sd_y;
  logic signed [TEMP_W-1:0] sd_temp;

  assign sr_kd   = {sr_phi, {YH_W{1'b0}}} + 64'(sr_plo);
  assign sr_diff = {1'b0, CVD_A_SQ} - {1'b0, sr_kd};

  always_ff @(posedge clk) begin
    if (rst) begin
      sd_tag <= '0;
    end else if (en) begin
      sd_tag <= '{valid: sr_tag.valid, fault: sr_tag.fault, poly: sr_tag.poly,
                  sat: sr_tag.sat || (!sr_tag.poly && sr_diff[64])};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd_rad  <= {1'b0, sr_diff[62:0]};
      sd_y    <= sr_y;
      sd_temp <= sr_temp;
    end
  end

  // square root of the discriminant
  tag_t                 sq_tag;
  logic [ROOT_W-1:0]    sq_root;
  logic [SQ_KEEP_W-1:0] sq_keep;

  rtdt_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_tag   (sd_tag),
    .in_rad   (sd_rad),
    .in_keep  ({sd_y, sd_temp}),
    .out_tag  (sq_tag),
    .out_root (sq_root),
    .out_keep (sq_keep)
  );

  // stage n: denominator and rounded numerator
  logic [DEN_W-1:0]  sq_den;
  tag_t              sn_tag;
  logic [NUM_W-1:0]  sn_num;
  logic [DEN_W-1:0]  sn_den;
  logic [TEMP_W-1:0] sn_temp;

  assign sq_den = DEN_W'(CVD_A_Q39) + DEN_W'(sq_root);

  always_ff @(posedge clk) begin
    if (rst) begin
      sn_tag <= '0;
    end else if (en) begin
      sn_tag <= sq_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sn_num  <= {sq_keep[SQ_KEEP_W-1:TEMP_W], {(NUM_W-Y_W){1'b0}}} +
                 NUM_W'(sq_den >> 1);
      sn_den  <= sq_den;
      sn_temp <= sq_keep[TEMP_W-1:0];
    end
  end

  // final divide
  tag_t              td_tag;
  logic [QT_W-1:0]   td_q;
  logic [TEMP_W-1:0] td_temp;

  rtdt_temp_div u_temp_div (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_tag       (sn_tag),
    .in_num       (sn_num),
    .in_den       (sn_den),
    .in_keep      (sn_temp),
    .out_tag      (td_tag),
    .out_quotient (td_q),
    .out_keep     (td_temp)
  );

  // output register: pick the branch result and saturate
  logic signed [TEMP_W-1:0] quad_temp;

  assign quad_temp = (|td_q[QT_W-1:TEMP_W-1]) ? TEMP_MAX : TEMP_W'(td_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= td_tag.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fault_seen      <= td_tag.fault;
      used_polynomial <= td_tag.poly || td_tag.sat;
      priority if (td_tag.sat) begin
        temperature <= TEMP_MAX;
      end else if (td_tag.poly) begin
        temperature <= td_temp;
      end else begin
        temperature <= quad_temp;
      end
    end
  end

  // checks
  a_quad_nonneg: assert property (@(posedge clk) disable iff (rst)
    out_valid && !used_polynomial |-> !temperature[TEMP_W-1])
    else $error("quadratic branch gave a negative temperature");

  a_stall_only_held: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with no result held");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

>>> sv/rtdt_ratio_div.sv
// pipelined restoring divider by the nominal resistance, one quotient bit per stage
module rtdt_ratio_div import rtdt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic [NOM_W-1:0]  divisor,
  input  tag_t              in_tag,
  input  logic [DIVD_W-1:0] in_dividend,
  output tag_t              out_tag,
  output logic [DIVD_W-1:0] out_quotient
);

  tag_t              tag_q [DIVD_W];
  logic [NOM_W-1:0]  rem_q [DIVD_W];
  logic [DIVD_W-1:0] dq_q  [DIVD_W];

  for (genvar i = 0; i < DIVD_W; i++) begin : g_stage
    tag_t              tag_in;
    logic [NOM_W-1:0]  rem_in;
    logic [DIVD_W-1:0] dq_in;
    logic [NOM_W:0]    part;

    if (i == 0) begin : g_first
      assign tag_in = in_tag;
      assign rem_in = '0;
      assign dq_in  = in_dividend;
    end else begin : g_next
      assign tag_in = tag_q[i-1];
      assign rem_in = rem_q[i-1];
      assign dq_in  = dq_q[i-1];
    end

    // shift in the next dividend bit
    assign part = {rem_in, dq_in[DIVD_W-1]};

    always_ff @(posedge clk) begin
      if (rst) begin
        tag_q[i] <= '0;
      end else if (en) begin
        tag_q[i] <= tag_in;
      end
    end

    // trial subtract, quotient bit enters at the bottom
    always_ff @(posedge clk) begin
      if (en) begin
        if (part >= {1'b0, divisor}) begin
          rem_q[i] <= NOM_W'(part - {1'b0, divisor});
          dq_q[i]  <= {dq_in[DIVD_W-2:0], 1'b1};
        end else begin
          rem_q[i] <= part[NOM_W-1:0];
          dq_q[i]  <= {dq_in[DIVD_W-2:0], 1'b0};
        end
      end
    end
  end

  assign out_tag      = tag_q[DIVD_W-1];
  assign out_quotient = dq_q[DIVD_W-1];

endmodule

>>> sv/rtdt_horner.sv
// fifth order polynomial by horner steps, two stages per step
module rtdt_horner import rtdt_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  tag_t                    in_tag,
  input  logic [U_W-1:0]          in_u,
  input  logic [Y_W-1:0]          in_keep,
  output tag_t                    out_tag,
  output logic signed [ACC_W-1:0] out_acc,
  output logic [Y_W-1:0]          out_keep
);

  localparam int HALF_W = ACC_W / 2;
  localparam int PL_W   = HALF_W + U_W;
  localparam int PH_W   = HALF_W + U_W + 1;
  localparam int PROD_W = PH_W + HALF_W;

  // multiply stage registers
  tag_t                   tag_a  [STEPS];
  logic [U_W-1:0]         u_a    [STEPS];
  logic [Y_W-1:0]         keep_a [STEPS];
  logic [PL_W-1:0]        pl_a   [STEPS];
  logic signed [PH_W-1:0] ph_a   [STEPS];

  // accumulate stage registers
  tag_t                    tag_b  [STEPS];
  logic [U_W-1:0]          u_b    [STEPS];
  logic [Y_W-1:0]          keep_b [STEPS];
  logic signed [ACC_W-1:0] acc_b  [STEPS];

  for (genvar j = 0; j < STEPS; j++) begin : g_step
    tag_t                     tag_in;
    logic [U_W-1:0]           u_in;
    logic [Y_W-1:0]           keep_in;
    logic signed [ACC_W-1:0]  acc_in;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] shifted;
    logic signed [PROD_W-1:0] trunc;

    if (j == 0) begin : g_first
      assign tag_in  = in_tag;
      assign u_in    = in_u;
      assign keep_in = in_keep;
      assign acc_in  = POLY_Q32[STEPS];
    end else begin : g_next
      assign tag_in  = tag_b[j-1];
      assign u_in    = u_b[j-1];
      assign keep_in = keep_b[j-1];
      assign acc_in  = acc_b[j-1];
    end

    // recombine partial products, then divide by 2^22 toward zero
    assign prod    = $signed({ph_a[j], {HALF_W{1'b0}}}) +
                     $signed({{(PROD_W-PL_W){1'b0}}, pl_a[j]});
    assign shifted = prod >>> U_W;
    assign trunc   = shifted + PROD_W'(prod[PROD_W-1] && (|prod[U_W-1:0]));

    always_ff @(posedge clk) begin
      if (rst) begin
        tag_a[j] <= '0;
        tag_b[j] <= '0;
      end else if (en) begin
        tag_a[j] <= tag_in;
        tag_b[j] <= tag_a[j];
      end
    end

    // split multiply of accumulator by u
    always_ff @(posedge clk) begin
      if (en) begin
        u_a[j]    <= u_in;
        keep_a[j] <= keep_in;
        pl_a[j]   <= acc_in[HALF_W-1:0] * u_in;
        ph_a[j]   <= $signed(acc_in[ACC_W-1:HALF_W]) * $signed({1'b0, u_in});
        u_b[j]    <= u_a[j];
        keep_b[j] <= keep_a[j];
        acc_b[j]  <= POLY_Q32[STEPS-1-j] + trunc[ACC_W-1:0];
      end
    end
  end

  assign out_tag  = tag_b[STEPS-1];
  assign out_acc  = acc_b[STEPS-1];
  assign out_keep = keep_b[STEPS-1];

endmodule

>>> sv/rtdt_sqrt.sv
// pipelined integer square root, one root bit per stage
module rtdt_sqrt import rtdt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  tag_t                 in_tag,
  input  logic [RAD_W-1:0]     in_rad,
  input  logic [SQ_KEEP_W-1:0] in_keep,
  output tag_t                 out_tag,
  output logic [ROOT_W-1:0]    out_root,
  output logic [SQ_KEEP_W-1:0] out_keep
);

  localparam int REM_W = ROOT_W + 2;

  tag_t                 tag_q  [ROOT_W];
  logic [REM_W-1:0]     rem_q  [ROOT_W];
  logic [ROOT_W-1:0]    root_q [ROOT_W];
  logic [RAD_W-1:0]     rad_q  [ROOT_W];
  logic [SQ_KEEP_W-1:0] keep_q [ROOT_W];

  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    tag_t                 tag_in;
    logic [REM_W-1:0]     rem_in;
    logic [ROOT_W-1:0]    root_in;
    logic [RAD_W-1:0]     rad_in;
    logic [SQ_KEEP_W-1:0] keep_in;
    logic [REM_W+1:0]     part;
    logic [REM_W+1:0]     trial;

    if (i == 0) begin : g_first
      assign tag_in  = in_tag;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = in_rad;
      assign keep_in = in_keep;
    end else begin : g_next
      assign tag_in  = tag_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign rad_in  = rad_q[i-1];
      assign keep_in = keep_q[i-1];
    end

    // bring down two radicand bits, trial is 4*root + 1
    assign part  = {rem_in, rad_in[RAD_W-1:RAD_W-2]};
    assign trial = {2'b00, root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (rst) begin
        tag_q[i] <= '0;
      end else if (en) begin
        tag_q[i] <= tag_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_q[i]  <= {rad_in[RAD_W-3:0], 2'b00};
        keep_q[i] <= keep_in;
        if (part >= trial) begin
          rem_q[i]  <= REM_W'(part - trial);
          root_q[i] <= {root_in[ROOT_W-2:0], 1'b1};
        end else begin
          rem_q[i]  <= part[REM_W-1:0];
          root_q[i] <= {root_in[ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign out_tag  = tag_q[ROOT_W-1];
  assign out_root = root_q[ROOT_W-1];
  assign out_keep = keep_q[ROOT_W-1];

endmodule

>>> sv/rtdt_temp_div.sv
// pipelined restoring divider for the final quotient, one bit per stage
module rtdt_temp_div import rtdt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  tag_t              in_tag,
  input  logic [NUM_W-1:0]  in_num,
  input  logic [DEN_W-1:0]  in_den,
  input  logic [TEMP_W-1:0] in_keep,
  output tag_t              out_tag,
  output logic [QT_W-1:0]   out_quotient,
  output logic [TEMP_W-1:0] out_keep
);

  tag_t              tag_q  [QT_W];
  logic [DEN_W-1:0]  rem_q  [QT_W];
  logic [QT_W-1:0]   dq_q   [QT_W];
  logic [DEN_W-1:0]  den_q  [QT_W];
  logic [TEMP_W-1:0] keep_q [QT_W];

  for (genvar i = 0; i < QT_W; i++) begin : g_stage
    tag_t              tag_in;
    logic [DEN_W-1:0]  rem_in;
    logic [QT_W-1:0]   dq_in;
    logic [DEN_W-1:0]  den_in;
    logic [TEMP_W-1:0] keep_in;
    logic [DEN_W:0]    part;

    // the top numerator bits are below the divisor, so they seed the remainder
    if (i == 0) begin : g_first
      assign tag_in  = in_tag;
      assign rem_in  = DEN_W'(in_num[NUM_W-1:QT_W]);
      assign dq_in   = in_num[QT_W-1:0];
      assign den_in  = in_den;
      assign keep_in = in_keep;
    end else begin : g_next
      assign tag_in  = tag_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign dq_in   = dq_q[i-1];
      assign den_in  = den_q[i-1];
      assign keep_in = keep_q[i-1];
    end

    assign part = {rem_in, dq_in[QT_W-1]};

    always_ff @(posedge clk) begin
      if (rst) begin
        tag_q[i] <= '0;
      end else if (en) begin
        tag_q[i] <= tag_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_q[i]  <= den_in;
        keep_q[i] <= keep_in;
        if (part >= {1'b0, den_in}) begin
          rem_q[i] <= DEN_W'(part - {1'b0, den_in});
          dq_q[i]  <= {dq_in[QT_W-2:0], 1'b1};
        end else begin
          rem_q[i] <= part[DEN_W-1:0];
          dq_q[i]  <= {dq_in[QT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign out_tag      = tag_q[QT_W-1];
  assign out_quotient = dq_q[QT_W-1];
  assign out_keep     = keep_q[QT_W-1];

endmodule
